FILE: hw/rtl/tdqe_pkg.sv
// Package for the target/decoy q-value engine: widths, request codes,
// status codes and controller-to-datapath command/status structs. No deps.
`timescale 1ns / 1ps

package tdqe_pkg;

  localparam int MaxPairsDefault = 1024;
  localparam int ScoreW = 32;
  localparam int IdxW = 10;
  localparam int RatioW = 17;
  localparam logic [RatioW-1:0] OneQ16 = 17'd65536;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_LDD = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  // Datapath operations driven by the controller.
  typedef enum logic [3:0] {
    OP_IDLE    = 4'd0,
    OP_CAPTURE = 4'd1,  // latch input transaction
    OP_RECIP   = 4'd2,  // one step of both reciprocal dividers
    OP_SCORE   = 4'd3,  // finalize scores
    OP_SHIFT   = 4'd4,  // one insertion shift step
    OP_RDIDX   = 4'd5,  // read load-order target
    OP_SRCH_D  = 4'd6,  // decoy lower-bound step
    OP_ADJ     = 4'd7,  // threshold adjust step
    OP_SRCH_T  = 4'd8,  // target lower-bound step
    OP_DIV     = 4'd9,  // one step of both ratio dividers
    OP_CLEAR   = 4'd10
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;  // first cycle of an index-read, search or divide phase
  } cmd_t;

  typedef struct packed {
    logic   done;      // current phase finished
    logic   full;
    logic   empty;
    logic   idx_bad;
    logic   mode;
  } sts_t;

endpackage

FILE: hw/rtl/tdqe_ram.sv
// Generic single-port RAM: reads every cycle, registered; writes on we.
// No dependencies.
`timescale 1ns / 1ps

module tdqe_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/tdqe_datapath.sv
// Datapath: score reciprocal, three score RAMs, insertion shift, binary
// searches and ratio dividers. Depends on tdqe_pkg and tdqe_ram.
`timescale 1ns / 1ps

module tdqe_datapath #(
  parameter int MaxPairs = tdqe_pkg::MaxPairsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdqe_pkg::cmd_t                cmd,
  output tdqe_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic signed [31:0]            in_td,
  input  logic signed [31:0]            in_tc,
  input  logic signed [31:0]            in_dd,
  input  logic signed [31:0]            in_dc,
  input  logic [tdqe_pkg::IdxW-1:0]     in_idx,
  output logic [tdqe_pkg::RatioW-1:0]   q_value,
  output logic [tdqe_pkg::RatioW-1:0]   decoy_ratio
);

  localparam int AW = $clog2(MaxPairs);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxPairs);
  localparam int IdxW_l = tdqe_pkg::IdxW;

  logic mode_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] ts_r, ds_r, thr_r;
  logic [31:0] tdiv_r, ddiv_r;
  logic [IdxW_l-1:0] idx_r;

  // ---------------- reciprocal: 2^32 / c, restoring on magnitudes ----------
  // Quotient of 2^32 / |c| needs 33 bits; iterate 33 steps.
  logic [32:0] tq_r, dq_r;       // remaining dividend bits / quotient
  logic [32:0] trm_r, drm_r;     // partial remainder
  logic [5:0]  rstep_r;
  logic        tneg, dneg;
  logic        tneg_r, dneg_r;

  assign tneg = in_tc[31];
  assign dneg = in_dc[31];

  function automatic logic signed [31:0] fin_score(input logic [32:0] q,
                                                   input logic neg,
                                                   input logic zero);
    logic signed [34:0] v;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (zero) return 32'sh7fffffff;
    if (v > 35'sh07fffffff) return 32'sh7fffffff;
    if (v < -35'sh080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------- RAMs ----------------
  logic          st_we, sd_we, lo_we;
  logic [AW-1:0] st_a, sd_a, lo_a;
  logic [31:0]   st_wd, sd_wd, lo_wd, st_rd, sd_rd, lo_rd;

  tdqe_ram #(.Width(32), .Depth(MaxPairs)) u_st (
    .clk(clk), .we(st_we), .addr(st_a), .wdata(st_wd), .rdata(st_rd));
  tdqe_ram #(.Width(32), .Depth(MaxPairs)) u_sd (
    .clk(clk), .we(sd_we), .addr(sd_a), .wdata(sd_wd), .rdata(sd_rd));
  tdqe_ram #(.Width(32), .Depth(MaxPairs)) u_lo (
    .clk(clk), .we(lo_we), .addr(lo_a), .wdata(lo_wd), .rdata(lo_rd));

  // ---------------- insertion: walk from top down ----------------
  // Position p runs cnt..0. Phase a reads p-1; phase b writes p with
  // either the read value (shift up) or the new score, per array.
  logic [CW-1:0] pos_r;
  logic          ph_r;
  logic          tdone_r, ddone_r;

  // ---------------- search state ----------------
  logic [CW-1:0] lo_r, hi_r, dlb_r, tlb_r;
  logic [1:0]    sph_r;
  logic signed [31:0] d0_r;

  logic [CW-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // ---------------- ratio dividers ----------------
  logic [CW+16:0] n1_r, n2_r, r1_r, r2_r;
  logic [CW-1:0]  den1_r;
  logic [5:0]     dstep_r;
  localparam int NW = CW + 17;

  logic done_r;
  logic [AW-1:0] rd_addr;

  always_comb begin
    st_we = 1'b0; sd_we = 1'b0; lo_we = 1'b0;
    st_a = '0; sd_a = '0; lo_a = '0;
    st_wd = ts_r; sd_wd = ds_r; lo_wd = ts_r;
    rd_addr = AW'(mid);
    unique case (cmd.op)
      tdqe_pkg::OP_SHIFT: begin
        st_a = AW'(ph_r ? pos_r : pos_r - 1'b1);
        sd_a = st_a;
        if (ph_r) begin
          st_we = !tdone_r;
          sd_we = !ddone_r;
          st_wd = (pos_r != '0 && $signed(st_rd) > ts_r) ? st_rd : ts_r;
          sd_wd = (pos_r != '0 && $signed(sd_rd) > ds_r) ? sd_rd : ds_r;
          lo_we = (pos_r == cnt_r);
          lo_a  = AW'(cnt_r);
        end
      end
      tdqe_pkg::OP_RDIDX: lo_a = AW'(idx_r);
      tdqe_pkg::OP_SRCH_D: sd_a = rd_addr;
      tdqe_pkg::OP_ADJ: sd_a = (sph_r == 2'd0) ? '0 : AW'(dlb_r - 1'b1);
      tdqe_pkg::OP_SRCH_T: st_a = rd_addr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.op == tdqe_pkg::OP_CLEAR) cnt_nxt = '0;
    else if (cmd.op == tdqe_pkg::OP_SHIFT && ph_r && pos_r == '0) cnt_nxt = cnt_r + 1'b1;
  end

  logic [32:0] ttrial, dtrial;
  logic [NW-1:0] t1, t2;
  logic [CW-1:0] nd;
  assign nd = cnt_r - dlb_r;
  assign ttrial = {trm_r[31:0], tq_r[32]};
  assign dtrial = {drm_r[31:0], dq_r[32]};
  assign t1 = {r1_r[NW-2:0], n1_r[NW-1]};
  assign t2 = {r2_r[NW-2:0], n2_r[NW-1]};

  // done_r is registered, so the controller sees it in the following cycle and
  // each phase still runs its operation while done_r is high; phases account for that.
  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    unique case (cmd.op)
      tdqe_pkg::OP_CAPTURE: begin
        idx_r <= in_idx;
        ts_r  <= in_td;
        ds_r  <= in_dd;
        tdiv_r <= tneg ? -in_tc : in_tc;
        ddiv_r <= dneg ? -in_dc : in_dc;
        tq_r  <= {1'b1, 32'd0};
        dq_r  <= {1'b1, 32'd0};
        trm_r <= '0;
        drm_r <= '0;
        rstep_r <= '0;
        tdone_r <= 1'b0;
        ddone_r <= 1'b0;
        pos_r <= cnt_r;
        ph_r  <= 1'b0;
      end
      tdqe_pkg::OP_RECIP: begin
        if (ttrial >= {1'b0, tdiv_r}) begin
          trm_r <= ttrial - {1'b0, tdiv_r}; tq_r <= {tq_r[31:0], 1'b1};
        end else begin
          trm_r <= ttrial; tq_r <= {tq_r[31:0], 1'b0};
        end
        if (dtrial >= {1'b0, ddiv_r}) begin
          drm_r <= dtrial - {1'b0, ddiv_r}; dq_r <= {dq_r[31:0], 1'b1};
        end else begin
          drm_r <= dtrial; dq_r <= {dq_r[31:0], 1'b0};
        end
        rstep_r <= rstep_r + 1'b1;
        // 33rd step runs in the cycle the controller sees done
        done_r <= (rstep_r == 6'd31);
      end
      tdqe_pkg::OP_SCORE: begin
        if (mode_r) begin
          ts_r <= fin_score(tq_r, tneg_r, tdiv_r == '0);
          ds_r <= fin_score(dq_r, dneg_r, ddiv_r == '0);
        end
        done_r <= !done_r;
      end
      tdqe_pkg::OP_SHIFT: begin
        if (ph_r) begin
          if (pos_r == '0 || !($signed(st_rd) > ts_r)) tdone_r <= 1'b1;
          if (pos_r == '0 || !($signed(sd_rd) > ds_r)) ddone_r <= 1'b1;
          done_r <= (pos_r == '0);
          pos_r <= pos_r - 1'b1;
        end
        ph_r <= !ph_r;
      end
      tdqe_pkg::OP_RDIDX: begin
        sph_r <= sph_r + 1'b1;
        if (cmd.start) sph_r <= 2'd0;
        if (sph_r == 2'd1) begin
          thr_r <= lo_rd;
          done_r <= 1'b1;
        end
        lo_r <= '0;
        hi_r <= cnt_r;
      end
      tdqe_pkg::OP_SRCH_D, tdqe_pkg::OP_SRCH_T: begin
        // Each step issues a read, then compares the registered data.
        if (cmd.start) begin
          ph_r <= 1'b0;
          lo_r <= '0;
          hi_r <= cnt_r;
        end else if (lo_r >= hi_r) begin
          if (cmd.op == tdqe_pkg::OP_SRCH_D) dlb_r <= lo_r;
          else tlb_r <= lo_r;
          done_r <= !done_r;
        end else if (ph_r) begin
          if ($signed(cmd.op == tdqe_pkg::OP_SRCH_D ? sd_rd : st_rd) < thr_r)
            lo_r <= mid + 1'b1;
          else
            hi_r <= mid;
          ph_r <= 1'b0;
        end else begin
          ph_r <= 1'b1;
        end
        sph_r <= '0;
      end
      tdqe_pkg::OP_ADJ: begin
        sph_r <= sph_r + 1'b1;
        if (sph_r == 2'd1) d0_r <= sd_rd;
        if (sph_r == 2'd2) begin
          if (dlb_r != '0 && $signed(sd_rd) > d0_r) begin
            dlb_r <= dlb_r - 1'b1;
            thr_r <= sd_rd;
          end
          done_r <= 1'b1;
        end
      end
      tdqe_pkg::OP_DIV: begin
        if (cmd.start) begin
          // numerator is decoys * 2^16
          n1_r <= {1'b0, nd, 16'd0};
          n2_r <= {1'b0, nd, 16'd0};
          r1_r <= '0;
          r2_r <= '0;
          den1_r <= (cnt_r == tlb_r) ? CW'(1) : cnt_r - tlb_r;
          dstep_r <= '0;
        end else begin
          if (t1 >= NW'(den1_r)) begin
            r1_r <= t1 - NW'(den1_r); n1_r <= {n1_r[NW-2:0], 1'b1};
          end else begin
            r1_r <= t1; n1_r <= {n1_r[NW-2:0], 1'b0};
          end
          if (t2 >= NW'(cnt_r)) begin
            r2_r <= t2 - NW'(cnt_r); n2_r <= {n2_r[NW-2:0], 1'b1};
          end else begin
            r2_r <= t2; n2_r <= {n2_r[NW-2:0], 1'b0};
          end
          dstep_r <= dstep_r + 1'b1;
          // last of NW steps runs in the cycle the controller sees done
          done_r <= (dstep_r == 6'(NW - 2));
        end
        sph_r <= '0;
      end
      default: sph_r <= '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tdqe_pkg::OP_CAPTURE) begin
      tneg_r <= tneg;
      dneg_r <= dneg;
    end
  end

  // Quotients are left in n*_r once all bits have been shifted in.
  assign q_value = (n1_r > NW'(tdqe_pkg::OneQ16)) ? tdqe_pkg::OneQ16
                                                  : n1_r[tdqe_pkg::RatioW-1:0];
  assign decoy_ratio = (n2_r > NW'(tdqe_pkg::OneQ16)) ? tdqe_pkg::OneQ16
                                                      : n2_r[tdqe_pkg::RatioW-1:0];

  assign sts.done    = done_r;
  assign sts.full    = (cnt_r == MaxCnt);
  assign sts.empty   = (cnt_r == '0);
  assign sts.idx_bad = (32'(in_idx) >= 32'(cnt_r));
  assign sts.mode    = mode_r;

endmodule

FILE: hw/rtl/tdqe_ctrl.sv
// Controller FSM: sequences load, query and clear phases and drives the
// output handshake. Depends on tdqe_pkg.
`timescale 1ns / 1ps

module tdqe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output tdqe_pkg::cmd_t      cmd,
  input  tdqe_pkg::sts_t      sts
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RECIP = 9'b000000010,
    S_SCORE = 9'b000000100,
    S_SHIFT = 9'b000001000,
    S_RDIDX = 9'b000010000,
    S_SRCHD = 9'b000100000,
    S_ADJ   = 9'b001000000,
    S_SRCHT = 9'b010000000,
    S_DIV   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   ov_r, ov_nxt;
  logic [1:0] st_r, st_nxt;
  logic   acc;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign acc       = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_status = st_r;

  always_comb begin
    state_nxt = state_r;
    first_nxt = 1'b0;
    ov_nxt    = ov_r && out_stall;
    st_nxt    = st_r;
    cmd.op    = tdqe_pkg::OP_IDLE;
    cmd.start = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (tdqe_pkg::req_t'(in_req_type))
            tdqe_pkg::REQ_LOAD: begin
              cmd.op = tdqe_pkg::OP_CAPTURE;
              if (!sts.full) begin
                state_nxt = S_RECIP;
              end
            end
            tdqe_pkg::REQ_QUERY: begin
              cmd.op = tdqe_pkg::OP_CAPTURE;
              ov_nxt = sts.empty || sts.idx_bad;
              st_nxt = sts.empty ? tdqe_pkg::ST_EMPTY :
                       sts.idx_bad ? tdqe_pkg::ST_NOT_LDD : tdqe_pkg::ST_OK;
              if (!sts.empty && !sts.idx_bad) begin
                state_nxt = S_RDIDX; first_nxt = 1'b1;
              end
            end
            tdqe_pkg::REQ_CLEAR: cmd.op = tdqe_pkg::OP_CLEAR;
            default: ;
          endcase
        end
      end
      S_RECIP: begin
        cmd.op = tdqe_pkg::OP_RECIP;
        if (sts.done) state_nxt = S_SCORE;
      end
      S_SCORE: begin
        cmd.op = tdqe_pkg::OP_SCORE;
        if (sts.done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.op = tdqe_pkg::OP_SHIFT;
        if (sts.done) state_nxt = S_IDLE;
      end
      S_RDIDX: begin
        cmd.op = tdqe_pkg::OP_RDIDX;
        if (sts.done) begin state_nxt = S_SRCHD; first_nxt = 1'b1; end
      end
      S_SRCHD: begin
        cmd.op = tdqe_pkg::OP_SRCH_D;
        if (sts.done) state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.op = tdqe_pkg::OP_ADJ;
        if (sts.done) begin state_nxt = S_SRCHT; first_nxt = 1'b1; end
      end
      S_SRCHT: begin
        cmd.op = tdqe_pkg::OP_SRCH_T;
        if (sts.done) begin state_nxt = S_DIV; first_nxt = 1'b1; end
      end
      S_DIV: begin
        cmd.op = tdqe_pkg::OP_DIV;
        if (sts.done) begin state_nxt = S_IDLE; ov_nxt = 1'b1; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      ov_r    <= 1'b0;
      st_r    <= tdqe_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      ov_r    <= ov_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

FILE: hw/rtl/target_decoy_qvalue_engine_top.sv
// Top level of the target/decoy q-value engine: controller plus datapath.
// Depends on tdqe_pkg, tdqe_ctrl, tdqe_datapath (and tdqe_ram below it).
//
//  channel | signals                          | role
//  --------+----------------------------------+------------------------------
//  in      | in_valid/in_stall + fields       | load, query or clear request
//  out     | out_valid/out_stall + fields     | one result per query
//  cfg     | cfg_we/cfg_wdata                 | score_mode register
//
// Sequence: a load keeps the input stalled through 33 reciprocal steps, the score
// phase, then the insertion shift, one read and one write per position. A query
// runs an index read, two binary searches of at most log2(pairs)+1 steps each, a
// threshold adjust, then a bit-serial ratio divider. Clear, ignored and rejected
// requests do not leave the idle state.
// Reset: rst_n synchronous, empties the stores and sets score_mode to 0.
// Stalls: no new transaction is taken while a result waits on out_stall.
`timescale 1ns / 1ps

module target_decoy_qvalue_engine_top #(
  parameter int MaxPairs = tdqe_pkg::MaxPairsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_req_type,
  input  logic [31:0]  in_target_discriminant,
  input  logic [31:0]  in_target_classifier,
  input  logic [31:0]  in_decoy_discriminant,
  input  logic [31:0]  in_decoy_classifier,
  input  logic [9:0]   in_entry_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [16:0]  out_q_value,
  output logic [16:0]  out_decoy_ratio,
  output logic [1:0]   out_status
);

  tdqe_pkg::cmd_t cmd;
  tdqe_pkg::sts_t sts;
  logic [16:0] qv, dr;

  tdqe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .cmd(cmd), .sts(sts));

  tdqe_datapath #(.MaxPairs(MaxPairs)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_td(in_target_discriminant), .in_tc(in_target_classifier),
    .in_dd(in_decoy_discriminant), .in_dc(in_decoy_classifier),
    .in_idx(in_entry_index),
    .q_value(qv), .decoy_ratio(dr));

  // Error statuses report zero ratios.
  assign out_q_value     = (out_status == tdqe_pkg::ST_OK) ? qv : '0;
  assign out_decoy_ratio = (out_status == tdqe_pkg::ST_OK) ? dr : '0;

endmodule

FILE: tb/sv/target_decoy_qvalue_engine_top_tb.sv
// Self-checking testbench for target_decoy_qvalue_engine_top: loads, queries and
// clears under random valid gaps and result stalls, checked by a cycle-free predictor.
// Depends on tdqe_pkg and the engine RTL.
`timescale 1ns / 1ps

module target_decoy_qvalue_engine_top_tb;
  import tdqe_pkg::*;

  // Full default capacity, so store behavior matches the spec'd pair limit.
  localparam int Cap = MaxPairsDefault;
  localparam int Settle = 2500;      // > one load at full capacity
  localparam int CycleLimit = 2000000;
  localparam int RandomItems = 560;

  typedef struct {
    req_t        req;
    logic [31:0] t_disc;
    logic [31:0] t_cls;
    logic [31:0] d_disc;
    logic [31:0] d_cls;
    logic [9:0]  idx;
  } request_t;

  typedef struct {
    logic [16:0] q_value;
    logic [16:0] decoy_ratio;
    status_t     status;
  } qresult_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_target_discriminant = '0;
  logic [31:0] in_target_classifier = '0;
  logic [31:0] in_decoy_discriminant = '0;
  logic [31:0] in_decoy_classifier = '0;
  logic [9:0]  in_entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] out_q_value;
  logic [16:0] out_decoy_ratio;
  logic [1:0]  out_status;

  target_decoy_qvalue_engine_top #(.MaxPairs(Cap)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_target_discriminant(in_target_discriminant),
    .in_target_classifier(in_target_classifier),
    .in_decoy_discriminant(in_decoy_discriminant),
    .in_decoy_classifier(in_decoy_classifier),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_q_value(out_q_value), .out_decoy_ratio(out_decoy_ratio),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the stores, the pair count and the mode.
  // ---------------------------------------------------------------------------
  int          tgt_sorted[Cap];
  int          dcy_sorted[Cap];
  int          tgt_by_load[Cap];
  int          n_pairs = 0;
  logic        mode_q = 1'b0;

  request_t    pending_reqs[$];   // transactions waiting for the driver
  qresult_t    expected_results[$];
  int          errors = 0;
  int          gen_pairs = 0;     // pair count as seen while generating stimulus

  // Score selection: discriminant, or saturated 2^32 / classifier in mode 1.
  function automatic int score_of(logic [31:0] disc, logic [31:0] cls);
    longint c;
    longint q;
    if (!mode_q) return int'(disc);
    c = longint'(int'(cls));
    if (c == 0) return 32'h7fffffff;
    q = 64'sd4294967296 / c;
    if (q > 64'sd2147483647) return 32'h7fffffff;
    if (q < -64'sd2147483648) return 32'h80000000;
    return int'(q);
  endfunction

  // New score goes after equal ones already stored.
  function automatic void insert_score(ref int arr[Cap], input int n, input int v);
    int pos;
    pos = 0;
    while (pos < n && arr[pos] <= v) pos++;
    for (int k = n; k > pos; k--) arr[k] = arr[k-1];
    arr[pos] = v;
  endfunction

  function automatic int lower_bound_of(ref int arr[Cap], input int n, input int v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (arr[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [16:0] q16_ratio(longint num, longint den);
    longint r;
    if (den == 0) den = 1;
    r = (num * 65536) / den;
    return (r > 65536) ? OneQ16 : r[16:0];
  endfunction

  // Applies one accepted transaction; queues a result for queries.
  function automatic void predict_qvalue(request_t r);
    qresult_t res;
    int ts;
    int ds;
    int thr;
    int dlb;
    int tlb;
    case (r.req)
      REQ_LOAD: begin
        if (n_pairs < Cap) begin
          ts = score_of(r.t_disc, r.t_cls);
          ds = score_of(r.d_disc, r.d_cls);
          insert_score(tgt_sorted, n_pairs, ts);
          insert_score(dcy_sorted, n_pairs, ds);
          tgt_by_load[n_pairs] = ts;
          n_pairs++;
        end
      end
      REQ_CLEAR: n_pairs = 0;
      REQ_QUERY: begin
        res.q_value = '0;
        res.decoy_ratio = '0;
        if (n_pairs == 0) res.status = ST_EMPTY;
        else if (int'(r.idx) >= n_pairs) res.status = ST_NOT_LDD;
        else begin
          thr = tgt_by_load[r.idx];
          dlb = lower_bound_of(dcy_sorted, n_pairs, thr);
          // threshold steps down to the next lower decoy unless that is the minimum
          if (dlb > 0 && dcy_sorted[dlb-1] > dcy_sorted[0]) begin
            dlb--;
            thr = dcy_sorted[dlb];
          end
          tlb = lower_bound_of(tgt_sorted, n_pairs, thr);
          res.q_value = q16_ratio(n_pairs - dlb, n_pairs - tlb);
          res.decoy_ratio = q16_ratio(n_pairs - dlb, n_pairs);
          res.status = ST_OK;
        end
        expected_results.insert(expected_results.size(), res);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Scores lean on extremes and a narrow band so ties and threshold moves happen.
  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return $urandom_range(0, 4) - 2;
      4, 5, 6: return ($urandom_range(0, 16) - 8) <<< 14;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_req(req_t kind, logic [9:0] idx = '0, logic [31:0] td = 0,
                                   logic [31:0] tc = 0, logic [31:0] dd = 0,
                                   logic [31:0] dc = 0);
    request_t r;
    r.req = kind;
    r.t_disc = td;
    r.t_cls = tc;
    r.d_disc = dd;
    r.d_cls = dc;
    r.idx = idx;
    pending_reqs.insert(pending_reqs.size(), r);
    if (kind == REQ_LOAD && gen_pairs < Cap) gen_pairs++;
    if (kind == REQ_CLEAR) gen_pairs = 0;
  endfunction

  function automatic void push_random_load();
    push_req(REQ_LOAD, 10'($urandom), rand_score(), rand_score(), rand_score(), rand_score());
  endfunction

  function automatic void push_random(int count);
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_random_load();
        made++;
      end else if (pick < 88) begin
        // mostly queries of loaded pairs, the rest any 10-bit index
        if (gen_pairs > 0 && $urandom_range(0, 9) < 8)
          push_req(REQ_QUERY, 10'($urandom_range(0, gen_pairs - 1)));
        else
          push_req(REQ_QUERY, 10'($urandom));
        made++;
      end else if (pick < 97) begin
        // clear now and then, always once the store has filled
        if (gen_pairs == Cap || $urandom_range(0, 9) == 0) begin
          push_req(REQ_CLEAR);
          made++;
        end
      end else begin
        push_req(REQ_NONE, 10'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endfunction

  // Sender pause: wait for the driver to drain and every result to come back,
  // then let any trailing load finish.
  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mode_q = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed part, then random phases over both score modes.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b0);

    // directed: empty store, extremes of every field, ignored request
    push_req(REQ_QUERY, 10'd0);                       // empty store
    push_req(REQ_NONE, 10'h3ff, '1, '1, '1, '1);      // unknown request, no result
    push_req(REQ_LOAD, 10'h3ff, 32'h7fffffff, 32'h0, 32'h80000000, 32'h1);
    push_req(REQ_LOAD, 10'h0, 32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h80000000);
    push_req(REQ_LOAD, 10'h0, 32'h0, 32'h7fffffff, 32'h0, 32'hffffffff);
    push_req(REQ_LOAD, 10'h0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);  // ties
    push_req(REQ_QUERY, 10'd0);
    push_req(REQ_QUERY, 10'd1);
    push_req(REQ_QUERY, 10'd3);
    push_req(REQ_QUERY, 10'd4);                       // index not loaded
    push_req(REQ_QUERY, 10'h3ff);
    for (int k = 0; k < 14; k++) push_random_load();
    push_req(REQ_QUERY, 10'(Cap - 1));
    push_req(REQ_CLEAR);
    push_req(REQ_QUERY, 10'd0);                       // empty again after clear
    wait_idle();

    // mode 1 directed: reciprocal extremes, zero divisor, -1 saturating low
    write_mode(1'b1);
    push_req(REQ_LOAD, 10'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    push_req(REQ_LOAD, 10'h0, 32'h0, 32'h1, 32'h0, 32'h80000000);
    push_req(REQ_LOAD, 10'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h20000);
    push_req(REQ_QUERY, 10'd0);
    push_req(REQ_QUERY, 10'd2);
    push_random(RandomItems / 4);
    wait_idle();

    write_mode(1'b0);
    push_random(RandomItems / 4);
    wait_idle();
    write_mode(1'b1);
    push_random(RandomItems / 4);
    wait_idle();
    write_mode(1'b0);
    push_random(RandomItems / 4);
    wait_idle();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; payload held while stalled.
  // ---------------------------------------------------------------------------
  int       burst_left = 0;
  int       gap_left = 0;
  request_t cur_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_qvalue(cur_req);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.req;
          in_target_discriminant <= cur_req.t_disc;
          in_target_classifier <= cur_req.t_cls;
          in_decoy_discriminant <= cur_req.d_disc;
          in_decoy_classifier <= cur_req.d_cls;
          in_entry_index <= cur_req.idx;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stall pattern is picked at random (none, light,
  // heavy, long runs); each delivered result is checked in order.
  // ---------------------------------------------------------------------------
  int       cycles = 0;
  int       stall_kind = 0;
  int       stall_run = 0;
  qresult_t want;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (cycles % 256 == 0) stall_kind = $urandom_range(0, 3);
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) stall_run = $urandom_range(1, 30);
        stall_run--;
        out_stall <= (((cycles / 32) % 2) == 1);
      end
    endcase
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result q=%0d ratio=%0d status=%0d", $time,
                 out_q_value, out_decoy_ratio, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_q_value !== want.q_value) begin
          $display("%0t: q_value expected %0d actual %0d", $time, want.q_value, out_q_value);
          errors++;
        end
        if (out_decoy_ratio !== want.decoy_ratio) begin
          $display("%0t: decoy_ratio expected %0d actual %0d", $time,
                   want.decoy_ratio, out_decoy_ratio);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

endmodule
